[design/irta_pkg.sv]
`default_nettype none

package irta_pkg;

	// Format commands carried in the low bits of the input beat
	localparam logic [2:0] CMD_UDEC    = 3'd0;
	localparam logic [2:0] CMD_SDEC    = 3'd1;
	localparam logic [2:0] CMD_HEX     = 3'd2;
	localparam logic [2:0] CMD_HEX_PFX = 3'd3;
	localparam logic [2:0] CMD_OCT     = 3'd4;
	localparam logic [2:0] CMD_BIN     = 3'd5;

	// Stream widths fixed by the field layout
	localparam int CMD_W       = 3;
	localparam int IN_VALUE_W  = 64;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 8;
	localparam int CHAR_W      = 7;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_LOW_A = 7'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CH_X     = 7'h78;

	// Digit sizes in bits (BCD and hex share four)
	localparam logic [2:0] DSZ_BIN = 3'd1;
	localparam logic [2:0] DSZ_OCT = 3'd3;
	localparam logic [2:0] DSZ_NIB = 3'd4;

	// Control of the shared shift unit
	typedef struct packed {
		logic       dabble;  // add-3 adjust then shift in one binary bit
		logic [2:0] dsz;     // otherwise shift left by this digit size
	} unit_ctl_t;

	// One digit (0..15) to its lowercase ASCII character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + CHAR_W'(d);
		end else begin
			return CH_LOW_A + CHAR_W'(d - 4'd10);
		end
	endfunction

endpackage

`default_nettype wire

[design/irta_shift_unit.sv]
`default_nettype none

// Shared digit unit: either one double-dabble step (add 3 to every BCD digit
// of 5 or more, then shift in one binary bit) or a left shift by one digit.
// Also presents the top digit of the current word.
module irta_shift_unit #(
	parameter int RW = 88
) (
	input  wire irta_pkg::unit_ctl_t ctl,
	input  wire logic [RW-1:0]       dig,
	input  wire logic                bit_in,
	output logic      [RW-1:0]       nxt,
	output logic      [3:0]          top
);

	localparam int NDIG = RW / 4;

	logic [RW-1:0] adj;
	logic [3:0]    top4;

	// BCD adjust, each digit on its own
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (dig[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = dig[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = dig[4*i +: 4];
			end
		end
	end

	// Next word
	always_comb begin
		if (ctl.dabble) begin
			nxt = {adj[RW-2:0], bit_in};
		end else begin
			case (ctl.dsz)
				irta_pkg::DSZ_BIN: nxt = dig << 1;
				irta_pkg::DSZ_OCT: nxt = dig << 3;
				irta_pkg::DSZ_NIB: nxt = dig << 4;
				default:           nxt = dig;
			endcase
		end
	end

	// Top digit, right aligned
	assign top4 = dig[RW-1 -: 4];
	always_comb begin
		case (ctl.dsz)
			irta_pkg::DSZ_BIN: top = {3'b000, top4[3]};
			irta_pkg::DSZ_OCT: top = {1'b0, top4[3:1]};
			default:           top = top4;
		endcase
	end

endmodule

`default_nettype wire

[design/integer_radix_to_ascii_unit.sv]
`default_nettype none

// Integer to ASCII formatter. Each input beat carries a command and a value
// (masked to VALUE_WIDTH bits); the block streams out the ASCII characters
// most significant digit first, one beat per character, with tlast on the
// final one. Commands: unsigned decimal, signed 32-bit decimal with a leading
// '-', lowercase hex, hex with "0x", octal, binary; zero prints as "0", and
// unused commands are taken and produce nothing. One number is handled at a
// time. Decimal runs shift-and-add-3 over every value bit in the shared
// digit unit. Every format then drops leading zero digits, keeping at least
// one, decides on sign or prefix and sends the characters, held back by
// output stalls. The last character sits in the output register while the
// next input is already accepted.
module integer_radix_to_ascii_unit #(
	parameter int VALUE_WIDTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// [2:0] command, [66:3] value, [71:67] zero
	input  wire logic [irta_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// [6:0] char_code, [7] zero
	output logic      [irta_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                       m_tlast
);

	localparam int DEC_DIGITS = (VALUE_WIDTH * 3) / 10 + 2;
	localparam int NIB_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
	localparam int RW         = 4 * DEC_DIGITS;
	localparam int CW         = $clog2(RW + 1);
	localparam int SH_HEX     = RW - 4 * NIB_DIGITS;
	localparam int SH_OCT     = RW - 3 * OCT_DIGITS;
	localparam int SH_BIN     = RW - VALUE_WIDTH;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_SKIP = 3'd2;
	localparam logic [2:0] S_SIGN = 3'd3;
	localparam logic [2:0] S_PX0  = 3'd4;
	localparam logic [2:0] S_PXX  = 3'd5;
	localparam logic [2:0] S_DIG  = 3'd6;

	logic [2:0]                    state_q, state_d;
	logic [CW-1:0]                 cnt_q, cnt_d;
	logic [2:0]                    dsz_q, dsz_d;
	logic                          neg_q, neg_d;
	logic                          pfx_q, pfx_d;
	logic                          ovalid_q, ovalid_d;
	logic [RW-1:0]                 dig_q, dig_d;
	logic [VALUE_WIDTH-1:0]        val_q, val_d;
	logic [irta_pkg::CHAR_W-1:0]   char_q, char_d;
	logic                          last_q, last_d;

	logic [irta_pkg::CMD_W-1:0]    in_cmd;
	logic [VALUE_WIDTH-1:0]        in_val;
	logic [VALUE_WIDTH+31:0]       in_ext;
	logic [31:0]                   s_low;
	logic [31:0]                   s_mag;
	logic [VALUE_WIDTH+31:0]       mag_ext;
	logic                          ld;

	irta_pkg::unit_ctl_t           uctl;
	logic [RW-1:0]                 u_nxt;
	logic [3:0]                    u_top;

	// Input fields
	assign in_cmd  = s_tdata[irta_pkg::CMD_W-1:0];
	assign in_val  = s_tdata[irta_pkg::CMD_W +: VALUE_WIDTH];
	assign in_ext  = {32'd0, in_val};
	assign s_low   = in_ext[31:0];
	assign s_mag   = s_low[31] ? (~s_low + 32'd1) : s_low;
	assign mag_ext = {{VALUE_WIDTH{1'b0}}, s_mag};

	// Shared digit unit
	assign uctl.dabble = (state_q == S_CONV);
	assign uctl.dsz    = dsz_q;

	irta_shift_unit #(
		.RW(RW)
	) u_shift (
		.ctl    (uctl),
		.dig    (dig_q),
		.bit_in (val_q[VALUE_WIDTH-1]),
		.nxt    (u_nxt),
		.top    (u_top)
	);

	// Output register free this cycle
	assign ld = !ovalid_q || m_tready;

	// Sequencer
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		dsz_d    = dsz_q;
		neg_d    = neg_q;
		pfx_d    = pfx_q;
		dig_d    = dig_q;
		val_d    = val_q;
		char_d   = char_q;
		last_d   = last_q;
		ovalid_d = ovalid_q && !m_tready;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					neg_d = 1'b0;
					pfx_d = 1'b0;
					dsz_d = irta_pkg::DSZ_NIB;
					dig_d = '0;
					val_d = in_val;
					unique case (in_cmd) inside
						irta_pkg::CMD_UDEC: begin
							cnt_d   = CW'(VALUE_WIDTH);
							state_d = S_CONV;
						end
						irta_pkg::CMD_SDEC: begin
							val_d   = mag_ext[VALUE_WIDTH-1:0];
							neg_d   = s_low[31];
							cnt_d   = CW'(VALUE_WIDTH);
							state_d = S_CONV;
						end
						irta_pkg::CMD_HEX, irta_pkg::CMD_HEX_PFX: begin
							dig_d   = RW'(in_val) << SH_HEX;
							cnt_d   = CW'(NIB_DIGITS);
							pfx_d   = (in_cmd == irta_pkg::CMD_HEX_PFX);
							state_d = S_SKIP;
						end
						irta_pkg::CMD_OCT: begin
							dig_d   = RW'(in_val) << SH_OCT;
							cnt_d   = CW'(OCT_DIGITS);
							dsz_d   = irta_pkg::DSZ_OCT;
							state_d = S_SKIP;
						end
						irta_pkg::CMD_BIN: begin
							dig_d   = RW'(in_val) << SH_BIN;
							cnt_d   = CW'(VALUE_WIDTH);
							dsz_d   = irta_pkg::DSZ_BIN;
							state_d = S_SKIP;
						end
						default: ;
					endcase
				end
			end
			// binary to BCD, one bit per cycle
			S_CONV: begin
				dig_d = u_nxt;
				val_d = val_q << 1;
				if (cnt_q == CW'(1)) begin
					cnt_d   = CW'(DEC_DIGITS);
					state_d = S_SKIP;
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			// drop leading zero digits, keep at least one
			S_SKIP: begin
				if (cnt_q > CW'(1) && u_top == 4'd0) begin
					dig_d = u_nxt;
					cnt_d = cnt_q - CW'(1);
				end else if (neg_q) begin
					state_d = S_SIGN;
				end else if (pfx_q) begin
					state_d = S_PX0;
				end else begin
					state_d = S_DIG;
				end
			end
			S_SIGN: begin
				if (ld) begin
					ovalid_d = 1'b1;
					char_d   = irta_pkg::CH_MINUS;
					last_d   = 1'b0;
					state_d  = S_DIG;
				end
			end
			S_PX0: begin
				if (ld) begin
					ovalid_d = 1'b1;
					char_d   = irta_pkg::CH_ZERO;
					last_d   = 1'b0;
					state_d  = S_PXX;
				end
			end
			S_PXX: begin
				if (ld) begin
					ovalid_d = 1'b1;
					char_d   = irta_pkg::CH_X;
					last_d   = 1'b0;
					state_d  = S_DIG;
				end
			end
			// one digit per beat
			S_DIG: begin
				if (ld) begin
					ovalid_d = 1'b1;
					char_d   = irta_pkg::digit_char(u_top);
					last_d   = (cnt_q == CW'(1));
					dig_d    = u_nxt;
					cnt_d    = cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			dsz_q    <= irta_pkg::DSZ_NIB;
			neg_q    <= 1'b0;
			pfx_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			dsz_q    <= dsz_d;
			neg_q    <= neg_d;
			pfx_q    <= pfx_d;
			ovalid_q <= ovalid_d;
		end
	end

	// Data registers
	always_ff @(posedge clk) begin
		dig_q  <= dig_d;
		val_q  <= val_d;
		char_q <= char_d;
		last_q <= last_d;
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

[test/integer_radix_to_ascii_unit_tb.sv]
`default_nettype none

module integer_radix_to_ascii_unit_tb;

	localparam int VALUE_WIDTH    = 64;
	localparam int RANDOM_NUMBERS = 130;
	localparam int CALM_TAIL      = 25;
	localparam int HOLDOFF_CYCLES = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 300;

	// Commands the block takes but ignores
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef logic [irta_pkg::CHAR_W-1:0] char_q_t[$];

	typedef struct packed {
		logic [irta_pkg::CHAR_W-1:0] code;
		logic                        last;
	} char_beat_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [63:0] value;
		bit          typed;
		string       text;
	} number_row_t;

	bit                                clk = 1'b0;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [irta_pkg::IN_TDATA_W-1:0]   s_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [irta_pkg::OUT_TDATA_W-1:0]  m_tdata;
	logic                              m_tlast;

	char_beat_t  pending_chars[$];
	number_row_t number_table[$];
	int          errors;
	int          chars_checked;
	int          numbers_per_cmd[8];
	int          quiet_cycles;
	bit          calm;
	bit          holdoff_req;

	integer_radix_to_ascii_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH @%0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
		errors++;
	endtask

	// Characters the block should print for one command/value pair
	function automatic char_q_t format_chars(input logic [2:0] cmd,
			input logic [63:0] value);
		char_q_t     text;
		char_q_t     digits;
		logic [63:0] mag;
		logic [63:0] radix;
		logic [63:0] digit;
		mag   = (VALUE_WIDTH >= 64) ? value : value & ((64'd1 << VALUE_WIDTH) - 64'd1);
		radix = 64'd10;
		case (cmd)
			irta_pkg::CMD_UDEC: radix = 64'd10;
			irta_pkg::CMD_SDEC: begin
				// low word is two's complement; 32-bit negate keeps 0x80000000 as is
				if (mag[31]) begin
					text.insert(text.size(), irta_pkg::CH_MINUS);
					mag = {32'd0, 32'd0 - mag[31:0]};
				end else begin
					mag = {32'd0, mag[31:0]};
				end
			end
			irta_pkg::CMD_HEX: radix = 64'd16;
			irta_pkg::CMD_HEX_PFX: begin
				radix = 64'd16;
				text.insert(text.size(), irta_pkg::CH_ZERO);
				text.insert(text.size(), irta_pkg::CH_X);
			end
			irta_pkg::CMD_OCT: radix = 64'd8;
			irta_pkg::CMD_BIN: radix = 64'd2;
			default: return text;
		endcase
		// zero still yields one digit
		do begin
			digit = mag % radix;
			if (digit < 64'd10) begin
				digits.push_front(irta_pkg::CH_ZERO + irta_pkg::CHAR_W'(digit));
			end else begin
				digits.push_front(irta_pkg::CH_LOW_A + irta_pkg::CHAR_W'(digit - 64'd10));
			end
			mag = mag / radix;
		end while (mag != 64'd0);
		foreach (digits[i]) text.insert(text.size(), digits[i]);
		return text;
	endfunction

	function automatic void add_row(input logic [2:0] cmd, input logic [63:0] value,
			input bit typed, input string text);
		number_row_t row;
		row.cmd   = cmd;
		row.value = value;
		row.typed = typed;
		row.text  = text;
		number_table.insert(number_table.size(), row);
	endfunction

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		int          bits;
		v    = {$urandom(), $urandom()};
		bits = $urandom_range(1, 64);
		case ($urandom_range(0, 5))
			0: ;
			1: if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
			2: v = 64'($urandom_range(0, 20));
			3: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
			4: v[31] = 1'b1;
			default: v = ~64'd0 >> $urandom_range(0, 63);
		endcase
		return v;
	endfunction

	// Offer one number; queue its characters once the beat is taken
	task automatic send_number(input logic [2:0] cmd, input logic [63:0] value,
			input bit typed, input string text);
		char_q_t chars;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= irta_pkg::IN_TDATA_W'({value, cmd});
		do @(posedge clk); while (!s_tready);
		if (typed) begin
			for (int i = 0; i < text.len(); i++)
				chars.insert(chars.size(), irta_pkg::CHAR_W'(text[i]));
		end else begin
			chars = format_chars(cmd, value);
		end
		foreach (chars[i])
			pending_chars.insert(pending_chars.size(),
				char_beat_t'{chars[i], i == chars.size() - 1});
		numbers_per_cmd[cmd]++;
		@(negedge clk);
	endtask

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	end

	// Check each output beat against the oldest expected character
	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n === 1'b1 && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch("unexpected character", 64'(m_tdata), 64'd0);
			end else begin
				want = pending_chars.pop_front();
				chars_checked++;
				if (m_tdata[irta_pkg::CHAR_W-1:0] !== want.code)
					report_mismatch("char_code", 64'(m_tdata[irta_pkg::CHAR_W-1:0]),
						64'(want.code));
				if (m_tdata[irta_pkg::OUT_TDATA_W-1:irta_pkg::CHAR_W] !== '0)
					report_mismatch("tdata pad",
						64'(m_tdata[irta_pkg::OUT_TDATA_W-1:irta_pkg::CHAR_W]), 64'd0);
				if (m_tlast !== want.last)
					report_mismatch("tlast", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	// Watchdog on cycles without any beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TIMEOUT: no beat for %0d cycles, %0d characters outstanding",
				quiet_cycles, pending_chars.size());
			$display("** integer_radix_to_ascii_unit: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int       numbers_sent;
		int       ignored_sent;
		logic [2:0] cmd;
		errors       = 0;
		chars_checked = 0;
		quiet_cycles = 0;
		calm         = 1'b0;
		holdoff_req  = 1'b0;
		numbers_sent = 0;
		ignored_sent = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;

		// Directed numbers: extremes of every format, sign handling, unused commands
		add_row(irta_pkg::CMD_UDEC,    64'd0, 1'b1, "0");
		add_row(irta_pkg::CMD_UDEC,    ~64'd0, 1'b1, "18446744073709551615");
		add_row(irta_pkg::CMD_UDEC,    64'd9, 1'b1, "9");
		add_row(irta_pkg::CMD_UDEC,    64'd10, 1'b0, "");
		add_row(irta_pkg::CMD_SDEC,    64'h0000_0000_8000_0000, 1'b1, "-2147483648");
		add_row(irta_pkg::CMD_SDEC,    64'h0000_0000_FFFF_FFFF, 1'b1, "-1");
		add_row(irta_pkg::CMD_SDEC,    64'h0000_0000_7FFF_FFFF, 1'b1, "2147483647");
		add_row(irta_pkg::CMD_SDEC,    64'd0, 1'b1, "0");
		add_row(irta_pkg::CMD_SDEC,    64'hDEAD_BEEF_0000_0007, 1'b0, "");
		add_row(irta_pkg::CMD_SDEC,    64'h1234_5678_FFFF_FF85, 1'b0, "");
		add_row(irta_pkg::CMD_HEX,     64'd0, 1'b1, "0");
		add_row(irta_pkg::CMD_HEX,     ~64'd0, 1'b1, "ffffffffffffffff");
		add_row(irta_pkg::CMD_HEX,     64'hABCD_EF01_2345_6789, 1'b0, "");
		add_row(irta_pkg::CMD_HEX_PFX, 64'd0, 1'b1, "0x0");
		add_row(irta_pkg::CMD_HEX_PFX, ~64'd0, 1'b1, "0xffffffffffffffff");
		add_row(irta_pkg::CMD_HEX_PFX, 64'h0000_0000_0000_FACE, 1'b0, "");
		add_row(irta_pkg::CMD_OCT,     64'd0, 1'b1, "0");
		add_row(irta_pkg::CMD_OCT,     ~64'd0, 1'b1, "1777777777777777777777");
		add_row(irta_pkg::CMD_OCT,     64'h8000_0000_0000_0000, 1'b0, "");
		add_row(irta_pkg::CMD_BIN,     64'd0, 1'b1, "0");
		add_row(irta_pkg::CMD_BIN,     64'd1, 1'b1, "1");
		add_row(irta_pkg::CMD_BIN,     ~64'd0, 1'b0, "");
		add_row(irta_pkg::CMD_BIN,     64'h8000_0000_0000_0001, 1'b0, "");
		add_row(CMD_SPARE_LO,          64'h0123_4567_89AB_CDEF, 1'b1, "");
		add_row(CMD_SPARE_HI,          ~64'd0, 1'b1, "");

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (number_table[i])
			send_number(number_table[i].cmd, number_table[i].value,
				number_table[i].typed, number_table[i].text);

		// Output held off while input keeps coming, so the block backs up
		holdoff_req = 1'b1;

		while (numbers_sent < RANDOM_NUMBERS) begin
			calm = (RANDOM_NUMBERS - numbers_sent) <= CALM_TAIL;
			if ($urandom_range(0, 9) == 0) begin
				cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
				ignored_sent++;
			end else begin
				cmd = 3'($urandom_range(0, 5));
				numbers_sent++;
			end
			send_number(cmd, random_value(), 1'b0, "");
		end
		s_tvalid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Formatted %0d numbers: %0d udec, %0d sdec, %0d hex, %0d 0x-hex,",
			numbers_per_cmd[0] + numbers_per_cmd[1] + numbers_per_cmd[2] +
			numbers_per_cmd[3] + numbers_per_cmd[4] + numbers_per_cmd[5],
			numbers_per_cmd[0], numbers_per_cmd[1], numbers_per_cmd[2],
			numbers_per_cmd[3]);
		$display("  %0d oct, %0d bin; %0d ignored",
			numbers_per_cmd[4], numbers_per_cmd[5],
			numbers_per_cmd[6] + numbers_per_cmd[7]);
		$display("Checked %0d characters under random stalls and one %0d-cycle %s",
			chars_checked, HOLDOFF_CYCLES, "output hold-off");
		$display("%0d mismatches", errors);
		if (errors == 0) begin
			$display("** integer_radix_to_ascii_unit: PASSED **");
		end else begin
			$display("** integer_radix_to_ascii_unit: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
design/irta_pkg.sv
design/irta_shift_unit.sv
design/integer_radix_to_ascii_unit.sv
test/integer_radix_to_ascii_unit_tb.sv
